// File: rtl/i2cbm_pkg.sv
// shared types and constants for the i2c bit-level master
`default_nettype none

package i2cbm_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_ACK   = 3'd3,
        CMD_NACK  = 3'd4,
        CMD_WAIT  = 3'd5,
        CMD_WRITE = 3'd6,
        CMD_READ  = 3'd7
    } cmd_t;

    // sequence phases, one-hot
    typedef enum logic [7:0] {
        PH0 = 8'b0000_0001,
        PH1 = 8'b0000_0010,
        PH2 = 8'b0000_0100,
        PH3 = 8'b0000_1000,
        PH4 = 8'b0001_0000,
        PH5 = 8'b0010_0000,
        PH6 = 8'b0100_0000,
        PH7 = 8'b1000_0000
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_SETUP       = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
    localparam logic [7:0] SETUP_RST       = 8'd1;
    localparam logic [7:0] POLL_LIMIT_RST  = 8'd10;

    // bits per byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // configuration register set
    typedef struct packed {
        logic [7:0] half_period;
        logic [7:0] setup;
        logic [7:0] poll_limit;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       ack;
        logic       rej;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/i2cbm_seq.sv
// line sequencer: sequence state and the per-tick step logic
`default_nettype none

module i2cbm_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire logic [2:0]     cmd_in,
    input  wire logic [7:0]     wdata_in,
    input  wire logic           sda_in,
    input  wire i2cbm_pkg::cfg_t cfg,
    output i2cbm_pkg::res_t     res
);
    import i2cbm_pkg::*;

    // sequence state apart from the tick timer
    typedef struct packed {
        cmd_t       cmd;
        phase_t     phase;
        logic [7:0] shift;
        logic [3:0] bits;
        logic [7:0] poll;
        logic       scl;
        logic       sda;
        logic       ack;
    } seq_state_t;

    // outcome of entering one phase
    typedef struct packed {
        seq_state_t st;
        logic       fin;
        logic       cont;
        logic [7:0] dly;
    } enter_res_t;

    // enter the current phase: apply levels, pick next phase and hold time
    function automatic enter_res_t seq_enter(seq_state_t s, logic [7:0] hp,
                                             logic [7:0] setup, logic sd);
        enter_res_t r;
        logic       first;
        r      = '0;
        r.st   = s;
        r.dly  = hp;
        first  = (s.cmd == CMD_ACK);
        unique case (s.cmd)
            CMD_START:
            begin
                unique case (s.phase)
                    PH0:
                    begin
                        r.st.scl = 1'b1; r.st.sda = 1'b1; r.st.phase = PH1;
                    end
                    PH1:
                    begin
                        r.st.sda = 1'b0; r.st.phase = PH2;
                    end
                    PH2:
                    begin
                        r.st.scl = 1'b0; r.st.phase = PH3;
                    end
                    default: r.fin = 1'b1;
                endcase
            end
            CMD_STOP:
            begin
                unique case (s.phase)
                    PH0:
                    begin
                        r.st.scl = 1'b0; r.st.sda = 1'b0; r.st.phase = PH1;
                        r.dly = 8'd1;
                    end
                    PH1:
                    begin
                        r.st.scl = 1'b1; r.st.phase = PH2;
                    end
                    PH2:
                    begin
                        r.st.sda = 1'b1; r.st.phase = PH3;
                    end
                    default: r.fin = 1'b1;
                endcase
            end
            CMD_ACK, CMD_NACK:
            begin
                unique case (s.phase)
                    PH0:
                    begin
                        r.st.scl = 1'b0; r.st.sda = first; r.st.phase = PH1;
                        r.dly = 8'd1;
                    end
                    PH1:
                    begin
                        r.st.sda = ~first; r.st.phase = PH2;
                        r.dly = 8'd1;
                    end
                    PH2:
                    begin
                        r.st.scl = 1'b1; r.st.phase = PH3;
                    end
                    default:
                    begin
                        r.st.scl = 1'b0; r.st.sda = first; r.fin = 1'b1;
                    end
                endcase
            end
            CMD_WAIT:
            begin
                unique case (s.phase)
                    PH0:
                    begin
                        r.st.scl = 1'b0; r.st.sda = 1'b1; r.st.phase = PH1;
                    end
                    PH1:
                    begin
                        r.st.scl = 1'b1; r.st.phase = PH2;
                    end
                    PH2:
                    begin
                        // poll sda once per half period
                        if (s.poll == 8'd0)
                        begin
                            r.st.ack = 1'b0; r.st.phase = PH4; r.cont = 1'b1;
                        end
                        else if (!sd)
                        begin
                            r.st.ack = 1'b1; r.st.scl = 1'b0; r.fin = 1'b1;
                        end
                        else
                        begin
                            r.st.poll = s.poll - 8'd1;
                        end
                    end
                    // timeout: stop condition
                    PH4:
                    begin
                        r.st.scl = 1'b0; r.st.sda = 1'b0; r.st.phase = PH5;
                        r.dly = 8'd1;
                    end
                    PH5:
                    begin
                        r.st.scl = 1'b1; r.st.phase = PH6;
                    end
                    PH6:
                    begin
                        r.st.sda = 1'b1; r.st.phase = PH7;
                    end
                    default: r.fin = 1'b1;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (s.phase)
                    PH0:
                    begin
                        r.st.scl = 1'b0; r.st.sda = s.shift[7]; r.st.phase = PH1;
                        r.dly  = setup;
                        r.cont = (setup == 8'd0);
                    end
                    PH1:
                    begin
                        r.st.scl = 1'b1; r.st.phase = PH2;
                    end
                    PH2:
                    begin
                        r.st.scl = 1'b0; r.st.phase = PH3;
                    end
                    default:
                    begin
                        r.st.shift = {s.shift[6:0], 1'b0};
                        if (s.bits <= 4'd1)
                        begin
                            r.st.bits = 4'd0; r.fin = 1'b1;
                        end
                        else
                        begin
                            r.st.bits = s.bits - 4'd1; r.st.phase = PH0; r.cont = 1'b1;
                        end
                    end
                endcase
            end
            CMD_READ:
            begin
                unique case (s.phase)
                    PH0:
                    begin
                        r.st.scl = 1'b0; r.st.sda = 1'b1; r.st.phase = PH1;
                    end
                    PH1:
                    begin
                        r.st.scl = 1'b1; r.st.phase = PH2;
                    end
                    default:
                    begin
                        r.st.shift = {s.shift[6:0], sd};
                        if (s.bits <= 4'd1)
                        begin
                            r.st.bits = 4'd0; r.st.scl = 1'b0; r.fin = 1'b1;
                        end
                        else
                        begin
                            r.st.bits = s.bits - 4'd1; r.st.phase = PH0; r.cont = 1'b1;
                        end
                    end
                endcase
            end
            default: r.fin = 1'b1;
        endcase
        return r;
    endfunction

    seq_state_t st_reg, st_next;
    logic [7:0] timer_reg, timer_next;

    seq_state_t s0;
    enter_res_t e1, e2, e3, sel;
    logic [7:0] hp;
    logic [7:0] timer_dec;
    cmd_t       cmd_new;
    logic       busy, run, start_cmd;

    // step logic for one tick
    always_comb
    begin
        hp        = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
        cmd_new   = cmd_t'(cmd_in);
        busy      = (st_reg.cmd != CMD_NONE);
        start_cmd = !busy && (cmd_new != CMD_NONE);
        timer_dec = timer_reg - 8'd1;

        s0         = st_reg;
        timer_next = timer_reg;
        run        = 1'b0;
        if (start_cmd)
        begin
            s0.cmd   = cmd_new;
            s0.phase = PH0;
            s0.shift = (cmd_new == CMD_WRITE) ? wdata_in : 8'd0;
            s0.bits  = BYTE_BITS;
            s0.poll  = cfg.poll_limit;
            s0.ack   = 1'b0;
            run      = 1'b1;
        end
        else if (busy)
        begin
            timer_next = timer_dec;
            run        = (timer_dec == 8'd0);
        end

        // at most three phases pass within one tick
        e1 = seq_enter(s0, hp, cfg.setup, sda_in);
        e2 = seq_enter(e1.st, hp, cfg.setup, sda_in);
        e3 = seq_enter(e2.st, hp, cfg.setup, sda_in);
        if (e1.fin || !e1.cont)
            sel = e1;
        else if (e2.fin || !e2.cont)
            sel = e2;
        else
            sel = e3;

        st_next = s0;
        res     = '0;
        res.rej = busy && (cmd_new != CMD_NONE);
        if (run)
        begin
            st_next = sel.st;
            if (sel.fin)
            begin
                st_next.cmd   = CMD_NONE;
                st_next.phase = PH0;
                timer_next    = 8'd0;
                res.done      = 1'b1;
                res.rdata     = (s0.cmd == CMD_READ) ? sel.st.shift : 8'd0;
                res.ack       = (s0.cmd == CMD_WAIT) && sel.st.ack;
            end
            else
            begin
                timer_next = sel.dly;
            end
        end
        res.scl  = st_next.scl;
        res.sda  = st_next.sda;
        res.busy = (st_next.cmd != CMD_NONE);
    end

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.cmd   <= CMD_NONE;
            st_reg.phase <= PH0;
            st_reg.shift <= 8'd0;
            st_reg.bits  <= 4'd0;
            st_reg.poll  <= 8'd0;
            st_reg.scl   <= 1'b1;
            st_reg.sda   <= 1'b1;
            st_reg.ack   <= 1'b0;
            timer_reg    <= 8'd0;
        end
        else if (step_en)
        begin
            st_reg    <= st_next;
            timer_reg <= timer_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2c_bit_level_master_unit.sv
// i2c bit-level master top level: config registers, input and result registers
// Path: an accepted tick word is held in the input register, and the sequencer
// step runs from there into the result register, which offers the result.
// Throughput: one tick word per cycle; the input side stalls only while the
// result register is full and stalled.
// Reset: asynchronous, active low; sequencer idle with SCL and SDA released,
// config registers at half period 5, setup 1, poll limit 10.
`default_nettype none

module i2c_bit_level_master_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // tick input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] command,
    input  wire logic [7:0] write_data,
    input  wire logic       sda_in,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            scl_out,
    output logic            sda_out,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_data,
    output logic            ack_seen,
    output logic            rejected,
    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import i2cbm_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [2:0] cmd_reg;
    logic [7:0] wdata_reg;
    logic       sda_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_valid_next;
    res_t       res_reg, res_step;
    logic       out_free, advance, in_take;

    // handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
            out_valid_next = 1'b1;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period <= HALF_PERIOD_RST;
            cfg_reg.setup       <= SETUP_RST;
            cfg_reg.poll_limit  <= POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HALF_PERIOD)
                cfg_reg.half_period <= cfg_data;
            else if (cfg_index == REG_SETUP)
                cfg_reg.setup <= cfg_data;
            else if (cfg_index == REG_POLL_LIMIT)
                cfg_reg.poll_limit <= cfg_data;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= command;
            wdata_reg <= write_data;
            sda_reg   <= sda_in;
        end
    end

    // sequencer step
    i2cbm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .cmd_in   (cmd_reg),
        .wdata_in (wdata_reg),
        .sda_in   (sda_reg),
        .cfg      (cfg_reg),
        .res      (res_step)
    );

    // result word register
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_step;
    end

    assign scl_out   = res_reg.scl;
    assign sda_out   = res_reg.sda;
    assign busy_res  = res_reg.busy;
    assign done_res  = res_reg.done;
    assign read_data = res_reg.rdata;
    assign ack_seen  = res_reg.ack;
    assign rejected  = res_reg.rej;

endmodule

`default_nettype wire

// File: rtl/i2cbm_chk.sv
// port-level checker for the i2c bit-level master, with its bind
`default_nettype none

module i2cbm_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       scl_out,
    input wire logic       sda_out,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] read_data,
    input wire logic       ack_seen,
    input wire logic       rejected
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(scl_out) && $stable(sda_out) && $stable(done_res))
        else $error("stalled result word changed");

    // input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a finished sequence leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // read data and ack only travel with done
    a_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> read_data == 8'd0 && !ack_seen)
        else $error("read data or ack outside a done word");

    // an ack ends with scl low and sda released
    a_ack_lines: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_seen |-> !scl_out && sda_out)
        else $error("line levels wrong after ack");

endmodule

bind i2c_bit_level_master_unit i2cbm_chk u_chk (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the i2c bit-level master: directed table, then random line traffic
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbm_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_WORDS     = 20;
    localparam logic [1:0] REG_SPARE = 2'd3;

    // directed row: command word, line level held while it runs, command poked while busy
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] wdata;
        logic       sda;
        cmd_t       busy_cmd;
        logic       typed;
        res_t       want;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] command = 3'd0;
    logic [7:0] write_data = 8'h00;
    logic       sda_in = 1'b1;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'h00;

    // line sequencer copy used for prediction
    logic [7:0] cfg_half = HALF_PERIOD_RST;
    logic [7:0] cfg_setup = SETUP_RST;
    logic [7:0] cfg_poll = POLL_LIMIT_RST;
    cmd_t       seq_cmd = CMD_NONE;
    logic [7:0] seq_phase = 8'd0;
    logic [7:0] seq_timer = 8'd0;
    logic [7:0] seq_shift = 8'd0;
    logic [3:0] seq_bits = 4'd0;
    logic [7:0] seq_poll = 8'd0;
    logic       scl_lvl = 1'b1;
    logic       sda_lvl = 1'b1;
    logic       ack_got = 1'b0;

    res_t       expected_lines[$];
    int         fails = 0;
    int         quiet_cycles = 0;
    int         stall_left = 0;
    bit         calm = 1'b0;
    int         ack_odds = 0;
    dir_row_t   dir_rows [16];

    i2c_bit_level_master_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .write_data (write_data),
        .sda_in     (sda_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .scl_out    (scl_out),
        .sda_out    (sda_out),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_data  (read_data),
        .ack_seen   (ack_seen),
        .rejected   (rejected),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // half period, a zero acts as one
    function automatic int half_ticks();
        return (cfg_half == 8'd0) ? 1 : int'(cfg_half);
    endfunction

    // stop sequence from phase base; hold ticks, -1 when finished
    function automatic int stop_part(logic [7:0] base);
        logic [7:0] rel;
        rel = seq_phase - base;
        case (rel)
            8'd0:
            begin
                scl_lvl = 1'b0;
                sda_lvl = 1'b0;
                seq_phase = base + 8'd1;
                return 1;
            end
            8'd1:
            begin
                scl_lvl = 1'b1;
                seq_phase = base + 8'd2;
                return half_ticks();
            end
            8'd2:
            begin
                sda_lvl = 1'b1;
                seq_phase = base + 8'd3;
                return half_ticks();
            end
            default: return -1;
        endcase
    endfunction

    // enter the current phase; hold ticks, 0 to go on at once, -1 when finished
    function automatic int enter_phase(logic sd);
        logic first;
        case (seq_cmd)
            CMD_START:
            begin
                if (seq_phase == 8'd0)
                begin
                    scl_lvl = 1'b1;
                    sda_lvl = 1'b1;
                    seq_phase = 8'd1;
                    return half_ticks();
                end
                if (seq_phase == 8'd1)
                begin
                    sda_lvl = 1'b0;
                    seq_phase = 8'd2;
                    return half_ticks();
                end
                if (seq_phase == 8'd2)
                begin
                    scl_lvl = 1'b0;
                    seq_phase = 8'd3;
                    return half_ticks();
                end
                return -1;
            end
            CMD_STOP: return stop_part(8'd0);
            CMD_ACK, CMD_NACK:
            begin
                first = (seq_cmd == CMD_ACK);
                if (seq_phase == 8'd0)
                begin
                    scl_lvl = 1'b0;
                    sda_lvl = first;
                    seq_phase = 8'd1;
                    return 1;
                end
                if (seq_phase == 8'd1)
                begin
                    sda_lvl = ~first;
                    seq_phase = 8'd2;
                    return 1;
                end
                if (seq_phase == 8'd2)
                begin
                    scl_lvl = 1'b1;
                    seq_phase = 8'd3;
                    return half_ticks();
                end
                scl_lvl = 1'b0;
                sda_lvl = first;
                return -1;
            end
            CMD_WAIT:
            begin
                if (seq_phase == 8'd0)
                begin
                    scl_lvl = 1'b0;
                    sda_lvl = 1'b1;
                    seq_phase = 8'd1;
                    return half_ticks();
                end
                if (seq_phase == 8'd1)
                begin
                    scl_lvl = 1'b1;
                    seq_phase = 8'd2;
                    return half_ticks();
                end
                if (seq_phase == 8'd2)
                begin
                    // poll: give up, see the ack, or try again a half period on
                    if (seq_poll == 8'd0)
                    begin
                        ack_got = 1'b0;
                        seq_phase = 8'd4;
                        return 0;
                    end
                    if (sd == 1'b0)
                    begin
                        ack_got = 1'b1;
                        scl_lvl = 1'b0;
                        return -1;
                    end
                    seq_poll = seq_poll - 8'd1;
                    return half_ticks();
                end
                if (seq_phase >= 8'd4)
                    return stop_part(8'd4);
                return -1;
            end
            CMD_WRITE:
            begin
                if (seq_phase == 8'd0)
                begin
                    scl_lvl = 1'b0;
                    sda_lvl = seq_shift[7];
                    seq_phase = 8'd1;
                    return int'(cfg_setup);
                end
                if (seq_phase == 8'd1)
                begin
                    scl_lvl = 1'b1;
                    seq_phase = 8'd2;
                    return half_ticks();
                end
                if (seq_phase == 8'd2)
                begin
                    scl_lvl = 1'b0;
                    seq_phase = 8'd3;
                    return half_ticks();
                end
                seq_shift = {seq_shift[6:0], 1'b0};
                if (seq_bits <= 4'd1)
                begin
                    seq_bits = 4'd0;
                    return -1;
                end
                seq_bits = seq_bits - 4'd1;
                seq_phase = 8'd0;
                return 0;
            end
            CMD_READ:
            begin
                if (seq_phase == 8'd0)
                begin
                    scl_lvl = 1'b0;
                    sda_lvl = 1'b1;
                    seq_phase = 8'd1;
                    return half_ticks();
                end
                if (seq_phase == 8'd1)
                begin
                    scl_lvl = 1'b1;
                    seq_phase = 8'd2;
                    return half_ticks();
                end
                seq_shift = {seq_shift[6:0], sd};
                if (seq_bits <= 4'd1)
                begin
                    seq_bits = 4'd0;
                    scl_lvl = 1'b0;
                    return -1;
                end
                seq_bits = seq_bits - 4'd1;
                seq_phase = 8'd0;
                return 0;
            end
            default: return -1;
        endcase
    endfunction

    // one tick of the line sequencer, giving the result word it causes
    function automatic res_t step_line(cmd_t c, logic [7:0] wd, logic sd);
        logic was_busy;
        logic rej;
        logic run;
        logic fin;
        cmd_t finished;
        int   d;
        res_t r;
        was_busy = (seq_cmd != CMD_NONE);
        rej = was_busy && (c != CMD_NONE);
        run = 1'b0;
        fin = 1'b0;
        finished = CMD_NONE;
        if (!was_busy && c != CMD_NONE)
        begin
            seq_cmd = c;
            seq_phase = 8'd0;
            seq_shift = (c == CMD_WRITE) ? wd : 8'h00;
            seq_bits = BYTE_BITS;
            seq_poll = cfg_poll;
            ack_got = 1'b0;
            run = 1'b1;
        end
        else if (was_busy)
        begin
            seq_timer = seq_timer - 8'd1;
            if (seq_timer == 8'd0)
                run = 1'b1;
        end
        while (run)
        begin
            d = enter_phase(sd);
            if (d < 0)
            begin
                fin = 1'b1;
                finished = seq_cmd;
                seq_cmd = CMD_NONE;
                seq_phase = 8'd0;
                seq_timer = 8'd0;
                run = 1'b0;
            end
            else if (d > 0)
            begin
                seq_timer = d[7:0];
                run = 1'b0;
            end
        end
        r.scl = scl_lvl;
        r.sda = sda_lvl;
        r.busy = (seq_cmd != CMD_NONE);
        r.done = fin;
        r.rdata = (fin && finished == CMD_READ) ? seq_shift : 8'h00;
        r.ack = fin && finished == CMD_WAIT && ack_got;
        r.rej = rej;
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
        fails++;
    endtask

    // offer one tick word and predict its result once taken
    task automatic send_word(input cmd_t c, input logic [7:0] wd, input logic sd,
                             input logic typed, input res_t want);
        int   gap;
        res_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        write_data <= wd;
        sda_in <= sd;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        r = step_line(c, wd, sd);
        expected_lines.push_back(typed ? want : r);
    endtask

    // one command, then ticks until the sequence has finished
    task automatic issue_cmd(input cmd_t c, input logic [7:0] wd, input logic sd,
                             input cmd_t busy_c, input logic typed, input res_t want);
        send_word(c, wd, sd, typed, want);
        while (seq_cmd != CMD_NONE)
            send_word(busy_c, 8'($urandom_range(0, 255)), sd, 1'b0, '0);
    endtask

    // stop offering words and let every result come back
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all registers back to back, the spare index too
    task automatic program_regs(input logic [7:0] h, input logic [7:0] s, input logic [7:0] l);
        cfg_we <= 1'b1;
        cfg_index <= REG_HALF_PERIOD;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= REG_SETUP;
        cfg_data <= s;
        @(posedge clk);
        cfg_index <= REG_POLL_LIMIT;
        cfg_data <= l;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data <= 8'($urandom_range(0, 255));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_half = h;
        cfg_setup = s;
        cfg_poll = l;
    endtask

    // random commands with random content, pokes while busy
    task automatic run_random(input int n_words);
        int   sent;
        cmd_t c;
        logic sd;
        sent = 0;
        while (sent < n_words || seq_cmd != CMD_NONE)
        begin
            if (seq_cmd == CMD_NONE)
            begin
                c = ($urandom_range(0, 99) < 15) ? CMD_NONE : cmd_t'($urandom_range(1, 7));
                if (c == CMD_WAIT)
                    ack_odds = $urandom_range(0, 2);
                sd = 1'($urandom_range(0, 1));
            end
            else
            begin
                c = (sent < n_words && $urandom_range(0, 9) == 0) ?
                    cmd_t'($urandom_range(1, 7)) : CMD_NONE;
                if (seq_cmd == CMD_WAIT)
                begin
                    case (ack_odds)
                        0: sd = 1'b1;
                        1: sd = ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
                        default: sd = 1'($urandom_range(0, 1));
                    endcase
                end
                else
                    sd = 1'($urandom_range(0, 1));
            end
            send_word(c, 8'($urandom_range(0, 255)), sd, 1'b0, '0);
            sent++;
        end
    endtask

    // result side: random stalls, check every word taken
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{scl_out, sda_out, busy_res, done_res, read_data, ack_seen, rejected};
            if (expected_lines.size() == 0)
            begin
                $display("result word at %0t with nothing expected", $realtime);
                fails++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (got.scl !== want.scl)
                    report_mismatch("scl_out", 8'(got.scl), 8'(want.scl));
                if (got.sda !== want.sda)
                    report_mismatch("sda_out", 8'(got.sda), 8'(want.sda));
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", 8'(got.busy), 8'(want.busy));
                if (got.done !== want.done)
                    report_mismatch("done_res", 8'(got.done), 8'(want.done));
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", got.rdata, want.rdata);
                if (got.ack !== want.ack)
                    report_mismatch("ack_seen", 8'(got.ack), 8'(want.ack));
                if (got.rej !== want.rej)
                    report_mismatch("rejected", 8'(got.rej), 8'(want.rej));
            end
        end
        if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15)
            stall_left = (pick_gap() == 0) ? 1 : pick_gap() + 1;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_CYCLES)
                begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        // directed rows at the reset settings
        dir_rows = '{
            '{CMD_NONE,  8'h00, 1'b1, CMD_NONE,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{CMD_START, 8'h00, 1'b1, CMD_NONE,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{CMD_WRITE, 8'hFF, 1'b1, CMD_NONE,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{CMD_WAIT,  8'h00, 1'b0, CMD_NONE,  1'b0, '0},
            '{CMD_WRITE, 8'h00, 1'b0, CMD_NONE,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{CMD_WAIT,  8'hFF, 1'b1, CMD_NONE,  1'b0, '0},
            '{CMD_READ,  8'h00, 1'b1, CMD_NONE,  1'b0, '0},
            '{CMD_ACK,   8'h00, 1'b1, CMD_NONE,  1'b0, '0},
            '{CMD_READ,  8'hFF, 1'b0, CMD_NONE,  1'b0, '0},
            '{CMD_NACK,  8'h00, 1'b0, CMD_NONE,  1'b0, '0},
            '{CMD_STOP,  8'h00, 1'b1, CMD_NONE,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{CMD_START, 8'h00, 1'b0, CMD_READ,  1'b0, '0},
            '{CMD_WRITE, 8'h5A, 1'b1, CMD_STOP,  1'b0, '0},
            '{CMD_WAIT,  8'h00, 1'b0, CMD_WRITE, 1'b0, '0},
            '{CMD_READ,  8'hA5, 1'b1, CMD_ACK,   1'b0, '0},
            '{CMD_STOP,  8'h00, 1'b0, CMD_START, 1'b0, '0}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = ($urandom_range(0, 3) == 0);
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].cmd, dir_rows[i].wdata, dir_rows[i].sda,
                      dir_rows[i].busy_cmd, dir_rows[i].typed, dir_rows[i].want);
        settle();

        // random phases: zero setup and poll limit, zero half period, then small settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: program_regs(8'd1, 8'd0, 8'd0);
                1: program_regs(8'd0, 8'd3, 8'd1);
                2: program_regs(8'd2, 8'd2, 8'd3);
                default: program_regs(8'($urandom_range(1, 3)), 8'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 5)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            run_random(PHASE_WORDS);
            settle();
        end

        if (expected_lines.size() != 0)
        begin
            $display("%0d result words never arrived", expected_lines.size());
            fails++;
        end
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: i2c_bit_level_master_unit.f
rtl/i2cbm_pkg.sv
rtl/i2cbm_seq.sv
rtl/i2c_bit_level_master_unit.sv
rtl/i2cbm_chk.sv
tb/sv/tb_top.sv
